>>> sv/ata_pio_sector_sequencer_top_defines.svh
// Assertion macros shared by the ATA PIO sector sequencer RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ATA_PIO_SECTOR_SEQUENCER_TOP_DEFINES_SVH
`define ATA_PIO_SECTOR_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/aps_pkg.sv
// Shared types and constants of the ATA PIO sector sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package aps_pkg;

  localparam int unsigned SECTOR_WORDS = 256;
  localparam int unsigned MAX_RES      = 8;
  localparam int unsigned RES_IDX_W    = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W    = $clog2(MAX_RES + 1);

  localparam logic [19:0] POLL_LIMIT_RST = 20'd1000000;

  // Configuration register index (byte address bit 2).
  localparam logic REG_POLL_LIMIT = 1'b0;

  // Input operations.
  localparam logic [1:0] OP_DETECT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_RESP   = 2'd3;

  // Result actions.
  localparam logic [2:0] ACT_RB      = 3'd0;
  localparam logic [2:0] ACT_WB      = 3'd1;
  localparam logic [2:0] ACT_RW      = 3'd2;
  localparam logic [2:0] ACT_WW      = 3'd3;
  localparam logic [2:0] ACT_FETCH   = 3'd4;
  localparam logic [2:0] ACT_DELIVER = 3'd5;
  localparam logic [2:0] ACT_DONE    = 3'd6;

  // Done status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NODEV = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  // Task file and control block ports.
  localparam logic [9:0] P_NONE  = 10'h000;
  localparam logic [9:0] P_DATA  = 10'h1F0;
  localparam logic [9:0] P_FEAT  = 10'h1F1;
  localparam logic [9:0] P_COUNT = 10'h1F2;
  localparam logic [9:0] P_LBA0  = 10'h1F3;
  localparam logic [9:0] P_LBA1  = 10'h1F4;
  localparam logic [9:0] P_LBA2  = 10'h1F5;
  localparam logic [9:0] P_DRIVE = 10'h1F6;
  localparam logic [9:0] P_CMD   = 10'h1F7;
  localparam logic [9:0] P_ALT   = 10'h3F6;

  // Command bytes and status bits.
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_FLUSH    = 8'hE7;
  localparam logic [7:0] DRV_LBA      = 8'hE0;
  localparam logic [7:0] DRV_DETECT   = 8'hA0;
  localparam int unsigned BIT_BSY = 7;
  localparam int unsigned BIT_DRQ = 3;
  localparam int unsigned BIT_ERR = 0;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  port;
    logic [15:0] value;
    logic [7:0]  word_index;
    logic [1:0]  status;
  } aps_res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]       cnt;
    aps_res_t [MAX_RES-1:0]     ent;
  } aps_list_t;

  function automatic aps_res_t mk(logic [2:0] act, logic [9:0] prt, logic [15:0] val,
                                  logic [7:0] idx, logic [1:0] st);
    aps_res_t r;
    r.action     = act;
    r.port       = prt;
    r.value      = val;
    r.word_index = idx;
    r.status     = st;
    return r;
  endfunction

  function automatic aps_res_t rb(logic [9:0] prt);
    return mk(ACT_RB, prt, 16'h0000, 8'h00, ST_OK);
  endfunction

  function automatic aps_res_t wb(logic [9:0] prt, logic [7:0] val);
    return mk(ACT_WB, prt, {8'h00, val}, 8'h00, ST_OK);
  endfunction

  function automatic aps_res_t done(logic [1:0] st);
    return mk(ACT_DONE, P_NONE, 16'h0000, 8'h00, st);
  endfunction

endpackage

`default_nettype wire

>>> sv/aps_step.sv
// Sequencer state and single-pass step logic: one registered item in, a list
// of up to eight results out. Depends on aps_pkg.
`default_nettype none

module aps_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire_i,
  input  wire logic [1:0]           op_i,
  input  wire logic [27:0]          lba_i,
  input  wire logic [15:0]          data_i,
  input  wire logic [19:0]          poll_limit_i,
  output aps_pkg::aps_list_t        list_o
);

  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_DET_DLY1   = 5'd1;
  localparam logic [4:0] PH_DET_DLY2   = 5'd2;
  localparam logic [4:0] PH_DET_STATUS = 5'd3;
  localparam logic [4:0] PH_DET_BSY    = 5'd4;
  localparam logic [4:0] PH_DET_MID    = 5'd5;
  localparam logic [4:0] PH_DET_HIGH   = 5'd6;
  localparam logic [4:0] PH_DET_DRQ    = 5'd7;
  localparam logic [4:0] PH_DET_DRAIN  = 5'd8;
  localparam logic [4:0] PH_RW_BSY0    = 5'd9;
  localparam logic [4:0] PH_RW_DLY1    = 5'd10;
  localparam logic [4:0] PH_RW_DLY2    = 5'd11;
  localparam logic [4:0] PH_RW_BSY1    = 5'd12;
  localparam logic [4:0] PH_RW_DRQ     = 5'd13;
  localparam logic [4:0] PH_RD_WORD    = 5'd14;
  localparam logic [4:0] PH_WR_FETCH   = 5'd15;
  localparam logic [4:0] PH_FL_BSY     = 5'd16;

  logic [4:0]  phase_r, phase_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [27:0] blk_r, blk_nxt;
  logic [19:0] polls_r, polls_nxt;
  logic [8:0]  wc_r, wc_nxt;
  logic [1:0]  dc_r, dc_nxt;

  logic [7:0]  b;
  logic [19:0] polls_dec;
  logic        bsy_busy, bsy_fail, drq_fail, drq_ok, dly_done, wc_more;
  logic [8:0]  wc_inc;
  logic [7:0]  drive_lba;
  logic [7:0]  cmd_rw;

  assign b         = data_i[7:0];
  assign polls_dec = polls_r - 20'd1;
  assign bsy_busy  = b[aps_pkg::BIT_BSY];
  assign bsy_fail  = bsy_busy && (polls_dec == 20'd0);
  // The DRQ wait spends its poll before it looks at DRQ.
  assign drq_fail  = b[aps_pkg::BIT_ERR] || (polls_dec == 20'd0);
  assign drq_ok    = !drq_fail && b[aps_pkg::BIT_DRQ];
  assign dly_done  = (dc_r == 2'd3);
  assign wc_inc    = wc_r + 9'd1;
  assign wc_more   = (wc_inc < 9'(aps_pkg::SECTOR_WORDS));
  assign drive_lba = aps_pkg::DRV_LBA | {4'h0, blk_r[27:24]};
  assign cmd_rw    = (kind_r == aps_pkg::OP_READ) ? aps_pkg::CMD_READ : aps_pkg::CMD_WRITE;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    blk_nxt   = blk_r;
    polls_nxt = polls_r;
    wc_nxt    = wc_r;
    dc_nxt    = dc_r;
    list_o    = '0;
    if (fire_i) begin
      if (op_i == aps_pkg::OP_RESP) begin
        unique case (phase_r) inside
          PH_DET_DLY1: begin
            if (!dly_done) begin
              dc_nxt = dc_r + 2'd1;
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_ALT);
              list_o.cnt    = 4'd1;
            end else begin
              list_o.ent[0] = aps_pkg::wb(aps_pkg::P_COUNT, 8'h00);
              list_o.ent[1] = aps_pkg::wb(aps_pkg::P_LBA0, 8'h00);
              list_o.ent[2] = aps_pkg::wb(aps_pkg::P_LBA1, 8'h00);
              list_o.ent[3] = aps_pkg::wb(aps_pkg::P_LBA2, 8'h00);
              list_o.ent[4] = aps_pkg::wb(aps_pkg::P_CMD, aps_pkg::CMD_IDENTIFY);
              list_o.ent[5] = aps_pkg::rb(aps_pkg::P_ALT);
              list_o.cnt    = 4'd6;
              dc_nxt        = 2'd0;
              phase_nxt     = PH_DET_DLY2;
            end
          end
          PH_DET_DLY2, PH_RW_DLY2: begin
            if (!dly_done) begin
              dc_nxt = dc_r + 2'd1;
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_ALT);
            end else begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
              if (phase_r == PH_DET_DLY2) begin
                phase_nxt = PH_DET_STATUS;
              end else begin
                polls_nxt = poll_limit_i;
                phase_nxt = PH_RW_BSY1;
              end
            end
            list_o.cnt = 4'd1;
          end
          PH_DET_STATUS: begin
            if (b == 8'h00) begin
              list_o.ent[0] = aps_pkg::done(aps_pkg::ST_NODEV);
              phase_nxt     = PH_IDLE;
            end else begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
              polls_nxt     = poll_limit_i;
              phase_nxt     = PH_DET_BSY;
            end
            list_o.cnt = 4'd1;
          end
          PH_DET_BSY, PH_RW_BSY0, PH_RW_BSY1: begin
            if (bsy_busy) begin
              polls_nxt = polls_dec;
              if (bsy_fail) begin
                list_o.ent[0] = aps_pkg::done(aps_pkg::ST_FAIL);
                phase_nxt     = PH_IDLE;
              end else begin
                list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
              end
              list_o.cnt = 4'd1;
            end else if (phase_r == PH_DET_BSY) begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_LBA1);
              list_o.cnt    = 4'd1;
              phase_nxt     = PH_DET_MID;
            end else if (phase_r == PH_RW_BSY0) begin
              list_o.ent[0] = aps_pkg::wb(aps_pkg::P_DRIVE, drive_lba);
              list_o.ent[1] = aps_pkg::rb(aps_pkg::P_ALT);
              list_o.cnt    = 4'd2;
              dc_nxt        = 2'd0;
              phase_nxt     = PH_RW_DLY1;
            end else begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
              list_o.cnt    = 4'd1;
              polls_nxt     = poll_limit_i;
              phase_nxt     = PH_RW_DRQ;
            end
          end
          PH_DET_MID, PH_DET_HIGH: begin
            if (b != 8'h00) begin
              // A nonzero signature byte means an ATAPI or unknown device.
              list_o.ent[0] = aps_pkg::done(aps_pkg::ST_NODEV);
              phase_nxt     = PH_IDLE;
            end else if (phase_r == PH_DET_MID) begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_LBA2);
              phase_nxt     = PH_DET_HIGH;
            end else begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
              polls_nxt     = poll_limit_i;
              phase_nxt     = PH_DET_DRQ;
            end
            list_o.cnt = 4'd1;
          end
          PH_DET_DRQ, PH_RW_DRQ: begin
            if (!b[aps_pkg::BIT_ERR]) begin
              polls_nxt = polls_dec;
            end
            if (drq_fail) begin
              list_o.ent[0] = aps_pkg::done(aps_pkg::ST_FAIL);
              phase_nxt     = PH_IDLE;
            end else if (!drq_ok) begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
            end else begin
              wc_nxt = 9'd0;
              if (phase_r == PH_RW_DRQ && kind_r != aps_pkg::OP_READ) begin
                list_o.ent[0] = aps_pkg::mk(aps_pkg::ACT_FETCH, aps_pkg::P_NONE, 16'h0000,
                                            8'h00, aps_pkg::ST_OK);
                phase_nxt     = PH_WR_FETCH;
              end else begin
                list_o.ent[0] = aps_pkg::mk(aps_pkg::ACT_RW, aps_pkg::P_DATA, 16'h0000,
                                            8'h00, aps_pkg::ST_OK);
                phase_nxt     = (phase_r == PH_DET_DRQ) ? PH_DET_DRAIN : PH_RD_WORD;
              end
            end
            list_o.cnt = 4'd1;
          end
          PH_DET_DRAIN: begin
            wc_nxt = wc_inc;
            if (wc_more) begin
              list_o.ent[0] = aps_pkg::mk(aps_pkg::ACT_RW, aps_pkg::P_DATA, 16'h0000,
                                          wc_inc[7:0], aps_pkg::ST_OK);
            end else begin
              list_o.ent[0] = aps_pkg::done(aps_pkg::ST_OK);
              phase_nxt     = PH_IDLE;
            end
            list_o.cnt = 4'd1;
          end
          PH_RW_DLY1: begin
            if (!dly_done) begin
              dc_nxt = dc_r + 2'd1;
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_ALT);
              list_o.cnt    = 4'd1;
            end else begin
              list_o.ent[0] = aps_pkg::wb(aps_pkg::P_FEAT, 8'h00);
              list_o.ent[1] = aps_pkg::wb(aps_pkg::P_COUNT, 8'h01);
              list_o.ent[2] = aps_pkg::wb(aps_pkg::P_LBA0, blk_r[7:0]);
              list_o.ent[3] = aps_pkg::wb(aps_pkg::P_LBA1, blk_r[15:8]);
              list_o.ent[4] = aps_pkg::wb(aps_pkg::P_LBA2, blk_r[23:16]);
              list_o.ent[5] = aps_pkg::wb(aps_pkg::P_CMD, cmd_rw);
              list_o.ent[6] = aps_pkg::rb(aps_pkg::P_ALT);
              list_o.cnt    = 4'd7;
              dc_nxt        = 2'd0;
              phase_nxt     = PH_RW_DLY2;
            end
          end
          PH_RD_WORD: begin
            list_o.ent[0] = aps_pkg::mk(aps_pkg::ACT_DELIVER, aps_pkg::P_NONE, data_i,
                                        wc_r[7:0], aps_pkg::ST_OK);
            wc_nxt = wc_inc;
            if (wc_more) begin
              list_o.ent[1] = aps_pkg::mk(aps_pkg::ACT_RW, aps_pkg::P_DATA, 16'h0000,
                                          wc_inc[7:0], aps_pkg::ST_OK);
            end else begin
              list_o.ent[1] = aps_pkg::done(aps_pkg::ST_OK);
              phase_nxt     = PH_IDLE;
            end
            list_o.cnt = 4'd2;
          end
          PH_WR_FETCH: begin
            list_o.ent[0] = aps_pkg::mk(aps_pkg::ACT_WW, aps_pkg::P_DATA, data_i,
                                        wc_r[7:0], aps_pkg::ST_OK);
            wc_nxt = wc_inc;
            if (wc_more) begin
              list_o.ent[1] = aps_pkg::mk(aps_pkg::ACT_FETCH, aps_pkg::P_NONE, 16'h0000,
                                          wc_inc[7:0], aps_pkg::ST_OK);
              list_o.cnt    = 4'd2;
            end else begin
              list_o.ent[1] = aps_pkg::wb(aps_pkg::P_CMD, aps_pkg::CMD_FLUSH);
              list_o.ent[2] = aps_pkg::rb(aps_pkg::P_CMD);
              list_o.cnt    = 4'd3;
              polls_nxt     = poll_limit_i;
              phase_nxt     = PH_FL_BSY;
            end
          end
          PH_FL_BSY: begin
            // Timeout and ready both end the flush with success.
            if (bsy_busy) begin
              polls_nxt = polls_dec;
            end
            if (bsy_busy && !bsy_fail) begin
              list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
            end else begin
              list_o.ent[0] = aps_pkg::done(aps_pkg::ST_OK);
              phase_nxt     = PH_IDLE;
            end
            list_o.cnt = 4'd1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end else if (phase_r == PH_IDLE) begin
        kind_nxt = op_i;
        if (op_i == aps_pkg::OP_DETECT) begin
          blk_nxt       = 28'd0;
          list_o.ent[0] = aps_pkg::wb(aps_pkg::P_DRIVE, aps_pkg::DRV_DETECT);
          list_o.ent[1] = aps_pkg::rb(aps_pkg::P_ALT);
          list_o.cnt    = 4'd2;
          dc_nxt        = 2'd0;
          phase_nxt     = PH_DET_DLY1;
        end else begin
          blk_nxt       = lba_i;
          polls_nxt     = poll_limit_i;
          list_o.ent[0] = aps_pkg::rb(aps_pkg::P_CMD);
          list_o.cnt    = 4'd1;
          phase_nxt     = PH_RW_BSY0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= 2'd0;
      blk_r   <= 28'd0;
      polls_r <= 20'd0;
      wc_r    <= 9'd0;
      dc_r    <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      blk_r   <= blk_nxt;
      polls_r <= polls_nxt;
      wc_r    <= wc_nxt;
      dc_r    <= dc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/aps_outq.sv
// Result list register and serializer: holds the results of one item and
// hands them out one per accepted cycle. Depends on aps_pkg and the defines.
`default_nettype none
`include "ata_pio_sector_sequencer_top_defines.svh"

module aps_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_i,
  input  aps_pkg::aps_list_t        list_i,
  output logic                      list_free_o,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_action,
  output logic [9:0]                out_port,
  output logic [15:0]               out_value,
  output logic [7:0]                out_word_index,
  output logic [1:0]                out_status,
  output logic                      out_last
);

  logic                                       valid_r;
  logic [aps_pkg::RES_CNT_W-1:0]              cnt_r;
  logic [aps_pkg::RES_IDX_W-1:0]              rd_r;
  aps_pkg::aps_res_t [aps_pkg::MAX_RES-1:0]   ent_r;
  aps_pkg::aps_res_t                          cur;
  logic                                       take;
  logic                                       last;

  assign cur  = ent_r[rd_r];
  assign last = ({1'b0, rd_r} == (cnt_r - 4'd1));
  assign take = valid_r && !out_stall;

  // A new list may land in the same cycle the final entry of the old one leaves.
  assign list_free_o = !valid_r || (take && last);

  assign out_valid      = valid_r;
  assign out_action     = cur.action;
  assign out_port       = cur.port;
  assign out_value      = cur.value;
  assign out_word_index = cur.word_index;
  assign out_status     = cur.status;
  assign out_last       = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      rd_r    <= '0;
    end else if (load_i) begin
      valid_r <= 1'b1;
      cnt_r   <= list_i.cnt;
      rd_r    <= '0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        rd_r <= rd_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      ent_r <= list_i.ent;
    end
  end

  `APS_ASSERT_IMP(a_cnt_nonzero, valid_r, cnt_r != 4'd0, "result list valid but empty")
  `APS_ASSERT_IMP(a_rd_in_range, valid_r, {1'b0, rd_r} < cnt_r, "read index past list end")
  `APS_ASSERT_IMP(a_load_free, load_i, list_free_o, "list loaded while results pending")
  `APS_ASSERT_NXT(a_rd_step, take && !last, rd_r == $past(rd_r) + 3'd1, "read index skipped")

endmodule

`default_nettype wire

>>> sv/ata_pio_sector_sequencer_top.sv
// Timing: an accepted item is registered in the input register, stepped once the
// result register can take its list, and its results are offered from that register.
// Throughput: one item per cycle while the result register drains; an item
// with k results holds it until all k are taken through the single read port.
// Reset (rst_n, synchronous): sequencer idle, pipeline empty, poll_limit 1000000.
// Top level of the ATA PIO sector sequencer; depends on aps_pkg, aps_step, aps_outq.
`default_nettype none

module ata_pio_sector_sequencer_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_operation,
  input  wire logic [27:0]  in_lba,
  input  wire logic [15:0]  in_data_in,
  // result channel
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_action,
  output logic [9:0]        out_port,
  output logic [15:0]       out_value,
  output logic [7:0]        out_word_index,
  output logic [1:0]        out_status,
  output logic              out_last
);

  logic [19:0]         poll_limit_r;
  logic                in_valid_r;
  logic [1:0]          op_r;
  logic [27:0]         lba_r;
  logic [15:0]         data_r;
  logic                list_free;
  logic                fire;
  logic                in_take;
  aps_pkg::aps_list_t  list;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == aps_pkg::REG_POLL_LIMIT) ? {12'h000, poll_limit_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= aps_pkg::POLL_LIMIT_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == aps_pkg::REG_POLL_LIMIT)) begin
      poll_limit_r <= pwdata[19:0];
    end
  end

  assign fire     = in_valid_r && list_free;
  assign in_stall = in_valid_r && !list_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_operation;
      lba_r  <= in_lba;
      data_r <= in_data_in;
    end
  end

  aps_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire_i       (fire),
    .op_i         (op_r),
    .lba_i        (lba_r),
    .data_i       (data_r),
    .poll_limit_i (poll_limit_r),
    .list_o       (list)
  );

  aps_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (fire && (list.cnt != 4'd0)),
    .list_i         (list),
    .list_free_o    (list_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_port       (out_port),
    .out_value      (out_value),
    .out_word_index (out_word_index),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
